// ===== hdl/residual_outlier_selector_assert.svh =====
// ----------------------------------------------------------------------------
// residual_outlier_selector assertion macros
// Shared property forms for the outlier selector checkers.
// ----------------------------------------------------------------------------
`ifndef RESIDUAL_OUTLIER_SELECTOR_ASSERT_SVH
`define RESIDUAL_OUTLIER_SELECTOR_ASSERT_SVH

// same-cycle implication, off while reset is held
`define ROS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ros implication check failed");

// next-cycle implication, off while reset is held
`define ROS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ros next-cycle check failed");

// property checked at every edge, reset included
`define ROS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("ros check failed");

`endif

// ===== hdl/ros_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ros_pkg
// Widths, register indexes, mode codes and limit helpers of the residual
// outlier selector.
// ----------------------------------------------------------------------------
package ros_pkg;

    localparam int SLOT_COUNT_DEF    = 64;
    localparam int RESIDUAL_BITS_DEF = 24;

    localparam int SLOT_W   = 6;
    localparam int SYS_W    = 3;
    localparam int SYS_N    = 5;
    localparam int LIMIT_W  = 12;
    localparam int LIMITS_W = LIMIT_W * SYS_N;
    localparam int LIM_W    = 16;
    localparam int NORM_W   = 16;
    localparam int MODE_W   = 2;
    localparam int KIND_N   = 4;
    localparam int KIND_W   = 2;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = LIMITS_W;

    localparam int OUT_DATA_W = 16;
    localparam int IN_USER_W  = 2;
    localparam int OUT_USER_W = 2;

    typedef logic [SLOT_W-1:0]   t_slot;
    typedef logic [SYS_W-1:0]    t_sys;
    typedef logic [LIMIT_W-1:0]  t_limit;
    typedef logic [LIMITS_W-1:0] t_limits;
    typedef logic [MODE_W-1:0]   t_mode;

    localparam logic [CFG_IDX_W-1:0] CFG_CODE_LIMITS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_LIMITS = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_NORM_LIMIT   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_RES_MODE     = CFG_IDX_W'(3);

    localparam t_mode MODE_ORIG = 2'd0;
    localparam t_mode MODE_NORM = 2'd1;
    localparam t_mode MODE_BOTH = 2'd2;

    // kind = {is_phase, is_norm}
    localparam logic [KIND_W-1:0] KIND_CODE_ORIG  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CODE_NORM  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PHASE_ORIG = 2'd2;
    localparam logic [KIND_W-1:0] KIND_PHASE_NORM = 2'd3;

    function automatic t_limit limit_field(input t_limits limits, input t_sys sys);
        t_limit f;
        f = '0;
        if (int'(sys) < SYS_N) begin
            f = limits[int'(sys) * LIMIT_W +: LIMIT_W];
        end
        return f;
    endfunction

endpackage

// ===== hdl/residual_outlier_selector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// residual_outlier_selector
// Running per-kind residual maxima and end-of-batch outlier decision.
// ----------------------------------------------------------------------------
// One residual beat is taken every cycle unless a beat with tlast set is held
// by a downstream stall; the rate is set by the compare-and-load of the four
// kind maximum registers. A result beat is produced only for a tlast beat and
// passes the snapshot, limit multiply and select stages, waiting while the
// master side stalls. The four kinds are code/phase times original/normalized;
// the maxima clear after each last beat, and no clearing pass follows reset.
// The user must write configuration only while the block is idle, unchecked.
module residual_outlier_selector #(
    parameter int SLOT_COUNT    = ros_pkg::SLOT_COUNT_DEF,
    parameter int RESIDUAL_BITS = ros_pkg::RESIDUAL_BITS_DEF,
    localparam int IN_DATA_W =
        ((ros_pkg::SLOT_W + ros_pkg::SYS_W + RESIDUAL_BITS + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ros_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ros_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // residual beats
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // sat_slot, gnss_system, residual_value, zero pad
    input  logic [IN_DATA_W-1:0]            i_s_axis_tdata,
    // is_phase, is_norm
    input  logic [ros_pkg::IN_USER_W-1:0]   i_s_axis_tuser,
    input  logic                            i_s_axis_tlast,
    // result beats
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // outlier_found, outlier_slot, outlier_system, zero pad
    output logic [ros_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // outlier_is_phase, chosen_by
    output logic [ros_pkg::OUT_USER_W-1:0]  o_m_axis_tuser
);

    localparam int MAG_W   = RESIDUAL_BITS - 1;
    localparam int PROD_W  = MAG_W + ros_pkg::LIM_W;
    localparam int SLOT_TB = 2 ** ros_pkg::SLOT_W;
    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
    localparam int KN = ros_pkg::KIND_N;

    // configuration
    ros_pkg::t_limits            r_code_limits;
    ros_pkg::t_limits            r_phase_limits;
    logic [ros_pkg::NORM_W-1:0]  r_norm_limit;
    ros_pkg::t_mode              r_mode;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_limits  <= '0;
            r_phase_limits <= '0;
            r_norm_limit   <= '0;
            r_mode         <= ros_pkg::MODE_ORIG;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ros_pkg::CFG_CODE_LIMITS:  r_code_limits  <= i_cfg_data;
                ros_pkg::CFG_PHASE_LIMITS: r_phase_limits <= i_cfg_data;
                ros_pkg::CFG_NORM_LIMIT:   r_norm_limit   <= i_cfg_data[ros_pkg::NORM_W-1:0];
                ros_pkg::CFG_RES_MODE:     r_mode         <= i_cfg_data[ros_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // slot reduction table
    ros_pkg::t_slot w_slot_mod [SLOT_TB];
    for (genvar gi = 0; gi < SLOT_TB; gi++) begin : g_slot_mod
        assign w_slot_mod[gi] = ros_pkg::SLOT_W'(gi % SLOT_COUNT);
    end

    // handshake chain
    logic r_s1_valid, r_j_valid, r_s3_valid, r_out_valid;
    logic r_in_last;
    logic w_out_ready, w_s3_ready, w_s2_ready, w_s1_take, w_in_acc;

    assign w_out_ready     = !r_out_valid || i_m_axis_tready;
    assign w_s3_ready      = !r_s3_valid || w_out_ready;
    assign w_s2_ready      = !r_j_valid || w_s3_ready;
    assign w_s1_take       = r_s1_valid && (!r_in_last || w_s2_ready);
    assign o_s_axis_tready = !r_s1_valid || w_s1_take;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    // input register
    ros_pkg::t_slot                r_in_slot;
    ros_pkg::t_sys                 r_in_sys;
    logic [ros_pkg::KIND_W-1:0]    r_in_kind;
    logic signed [RESIDUAL_BITS-1:0] r_in_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_take) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_slot  <= w_slot_mod[i_s_axis_tdata[ros_pkg::SLOT_W-1:0]];
            r_in_sys   <= i_s_axis_tdata[ros_pkg::SLOT_W +: ros_pkg::SYS_W];
            r_in_kind  <= {i_s_axis_tuser[0], i_s_axis_tuser[1]};
            r_in_value <= i_s_axis_tdata[ros_pkg::SLOT_W + ros_pkg::SYS_W +: RESIDUAL_BITS];
            r_in_last  <= i_s_axis_tlast;
        end
    end

    // magnitude with saturation of the most negative value
    logic [RESIDUAL_BITS-1:0] w_abs;
    logic [MAG_W-1:0]         w_mag;

    assign w_abs = r_in_value[RESIDUAL_BITS-1] ? (~r_in_value + 1'b1) : r_in_value;
    assign w_mag = w_abs[RESIDUAL_BITS-1] ? MAG_MAX : w_abs[MAG_W-1:0];

    // per-kind running maxima
    logic [MAG_W-1:0] r_kmag  [KN];
    ros_pkg::t_slot   r_kslot [KN];
    ros_pkg::t_sys    r_ksys  [KN];
    logic             r_kseen [KN];

    logic [MAG_W-1:0] n_kmag  [KN];
    ros_pkg::t_slot   n_kslot [KN];
    ros_pkg::t_sys    n_ksys  [KN];
    logic             n_kseen [KN];

    always_comb begin
        for (int k = 0; k < KN; k++) begin
            n_kmag[k]  = r_kmag[k];
            n_kslot[k] = r_kslot[k];
            n_ksys[k]  = r_ksys[k];
            n_kseen[k] = r_kseen[k];
            if (r_in_kind == ros_pkg::KIND_W'(k)) begin
                n_kseen[k] = 1'b1;
                if (r_kmag[k] == '0 || w_mag > r_kmag[k]) begin
                    n_kmag[k]  = w_mag;
                    n_kslot[k] = r_in_slot;
                    n_ksys[k]  = r_in_sys;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KN; k++) begin
                r_kmag[k]  <= '0;
                r_kslot[k] <= '0;
                r_ksys[k]  <= '0;
                r_kseen[k] <= 1'b0;
            end
        end else if (w_s1_take) begin
            for (int k = 0; k < KN; k++) begin
                if (r_in_last) begin
                    r_kmag[k]  <= '0;
                    r_kslot[k] <= '0;
                    r_ksys[k]  <= '0;
                    r_kseen[k] <= 1'b0;
                end else begin
                    r_kmag[k]  <= n_kmag[k];
                    r_kslot[k] <= n_kslot[k];
                    r_ksys[k]  <= n_ksys[k];
                    r_kseen[k] <= n_kseen[k];
                end
            end
        end
    end

    // batch snapshot
    logic [MAG_W-1:0] r_jmag  [KN];
    ros_pkg::t_slot   r_jslot [KN];
    ros_pkg::t_sys    r_jsys  [KN];
    logic             r_jseen [KN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_valid <= 1'b0;
        end else if (w_s2_ready) begin
            r_j_valid <= w_s1_take && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_take && r_in_last) begin
            for (int k = 0; k < KN; k++) begin
                r_jmag[k]  <= n_kmag[k];
                r_jslot[k] <= n_kslot[k];
                r_jsys[k]  <= n_ksys[k];
                r_jseen[k] <= n_kseen[k];
            end
        end
    end

    // limits, tests and cross products; index 0 code, 1 phase
    logic [ros_pkg::LIM_W-1:0] w_lim  [2];
    logic [ros_pkg::LIM_W-1:0] w_code16;

    assign w_code16 = ros_pkg::LIM_W'(ros_pkg::limit_field(r_code_limits,
                                                           r_jsys[ros_pkg::KIND_CODE_ORIG]));
    assign w_lim[0] = (w_code16 << 3) + (w_code16 << 1);
    assign w_lim[1] = ros_pkg::LIM_W'(ros_pkg::limit_field(r_phase_limits,
                                                           r_jsys[ros_pkg::KIND_PHASE_ORIG]));

    logic              r_fail_o [2];
    logic              r_fail_n [2];
    logic [PROD_W-1:0] r_prod_n [2];
    logic [PROD_W-1:0] r_prod_o [2];
    logic              r_seen_o [2];
    logic              r_seen_n [2];
    ros_pkg::t_slot    r_slot_o [2];
    ros_pkg::t_slot    r_slot_n [2];
    ros_pkg::t_sys     r_sys_o  [2];
    ros_pkg::t_sys     r_sys_n  [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_s3_ready) begin
            r_s3_valid <= r_j_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s3_ready && r_j_valid) begin
            for (int t = 0; t < 2; t++) begin
                r_fail_o[t] <= PROD_W'(r_jmag[2*t]) > PROD_W'(w_lim[t]);
                r_fail_n[t] <= PROD_W'(r_jmag[2*t+1]) > PROD_W'(r_norm_limit);
                r_prod_n[t] <= PROD_W'(r_jmag[2*t+1]) * PROD_W'(w_lim[t]);
                r_prod_o[t] <= PROD_W'(r_jmag[2*t]) * PROD_W'(r_norm_limit);
                r_seen_o[t] <= r_jseen[2*t];
                r_seen_n[t] <= r_jseen[2*t+1];
                r_slot_o[t] <= r_jslot[2*t];
                r_slot_n[t] <= r_jslot[2*t+1];
                r_sys_o[t]  <= r_jsys[2*t];
                r_sys_n[t]  <= r_jsys[2*t+1];
            end
        end
    end

    // per-type decision, phase before code
    logic w_found [2];
    logic w_use_n [2];

    always_comb begin
        for (int t = 0; t < 2; t++) begin
            w_found[t] = 1'b0;
            w_use_n[t] = 1'b0;
            unique case (r_mode)
                ros_pkg::MODE_ORIG: begin
                    w_found[t] = r_fail_o[t];
                end
                ros_pkg::MODE_NORM: begin
                    w_found[t] = r_fail_n[t];
                    w_use_n[t] = 1'b1;
                end
                ros_pkg::MODE_BOTH: begin
                    w_found[t] = r_fail_o[t] || r_fail_n[t];
                    w_use_n[t] = r_seen_n[t] && (r_slot_o[t] != r_slot_n[t])
                                 && (r_prod_n[t] >= r_prod_o[t]);
                end
                default: begin
                    w_found[t] = 1'b0;
                end
            endcase
            w_found[t] = w_found[t] && r_seen_o[t];
        end
    end

    logic           n_out_found, n_out_phase, n_out_by;
    ros_pkg::t_slot n_out_slot;
    ros_pkg::t_sys  n_out_sys;

    always_comb begin
        n_out_found = 1'b0;
        n_out_phase = 1'b0;
        n_out_by    = 1'b0;
        n_out_slot  = '0;
        n_out_sys   = '0;
        priority if (w_found[1]) begin
            n_out_found = 1'b1;
            n_out_phase = 1'b1;
            n_out_by    = w_use_n[1];
            n_out_slot  = w_use_n[1] ? r_slot_n[1] : r_slot_o[1];
            n_out_sys   = w_use_n[1] ? r_sys_n[1] : r_sys_o[1];
        end else if (w_found[0]) begin
            n_out_found = 1'b1;
            n_out_by    = w_use_n[0];
            n_out_slot  = w_use_n[0] ? r_slot_n[0] : r_slot_o[0];
            n_out_sys   = w_use_n[0] ? r_sys_n[0] : r_sys_o[0];
        end else begin
            n_out_found = 1'b0;
        end
    end

    // output register
    logic           r_out_found, r_out_phase, r_out_by;
    ros_pkg::t_slot r_out_slot;
    ros_pkg::t_sys  r_out_sys;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready && r_s3_valid) begin
            r_out_found <= n_out_found;
            r_out_phase <= n_out_phase;
            r_out_by    <= n_out_by;
            r_out_slot  <= n_out_slot;
            r_out_sys   <= n_out_sys;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = ros_pkg::OUT_DATA_W'({r_out_sys, r_out_slot, r_out_found});
    assign o_m_axis_tuser  = {r_out_by, r_out_phase};

endmodule

// ===== hdl/ros_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ros_checker
// Port-level checks on the result side of the residual outlier selector.
// ----------------------------------------------------------------------------
`include "residual_outlier_selector_assert.svh"

module ros_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    // outlier_found, outlier_slot, outlier_system, zero pad
    input logic [ros_pkg::OUT_DATA_W-1:0]  i_m_axis_tdata,
    // outlier_is_phase, chosen_by
    input logic [ros_pkg::OUT_USER_W-1:0]  i_m_axis_tuser
);

    `ROS_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !i_m_axis_tvalid)
    `ROS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_m_axis_tvalid && !i_m_axis_tready, i_m_axis_tvalid && $stable(i_m_axis_tdata) && $stable(i_m_axis_tuser))
    `ROS_ASSERT_IMPLY(a_none_zero, i_clk, i_rst_n, i_m_axis_tvalid && !i_m_axis_tdata[0], i_m_axis_tdata == '0 && i_m_axis_tuser == '0)
    `ROS_ASSERT_IMPLY(a_pad_zero, i_clk, i_rst_n, i_m_axis_tvalid, i_m_axis_tdata[ros_pkg::OUT_DATA_W-1:10] == '0)

endmodule

bind residual_outlier_selector ros_checker u_ros_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tuser  (o_m_axis_tuser)
);
